### hdl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared constants, codes and pipeline payload types of the color space
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int unsigned FULL  = 4095;          // 1.0 in a 12-bit fraction
  localparam int unsigned SEXT  = 960;           // one sextant, 1/16 degree
  localparam int unsigned TURN  = 5760;          // one full turn
  localparam int unsigned FSEXT = FULL * SEXT;   // HSV blend denominator
  localparam int unsigned DEN2  = 2 * FULL * SEXT;

  localparam int unsigned LANES = 3;
  localparam int unsigned QW    = 13;            // quotient bits
  localparam int unsigned NUMW  = 35;            // raw numerator
  localparam int unsigned DENW  = 23;            // raw denominator
  localparam int unsigned RW    = 36;            // 2*num + den
  localparam int unsigned DW    = 24;            // 2*den

  typedef enum logic [1:0] {
    CMD_HSV2RGB = 2'd0,
    CMD_RGB2HSV = 2'd1,
    CMD_HSL2RGB = 2'd2,
    CMD_RGB2HSL = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SRC_R,
    SRC_G,
    SRC_B
  } max_src_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  k;
    logic [9:0]  t;
    logic [11:0] s;
    logic [11:0] c;      // value or lightness
    logic [11:0] ch;     // HSL chroma
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
    logic [11:0] mx;
    logic [11:0] d;
    logic [12:0] sum;
    logic [11:0] hden;
    max_src_e    src;
  } s1_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  k;
    logic [9:0]  t;
    logic [11:0] c;
    logic [21:0] p_sv;
    logic [23:0] lo_v;
    logic [23:0] cs;
    logic [25:0] hue_num;
    logic [23:0] sat_num;
    logic [11:0] mx;
    logic [11:0] d;
    logic [12:0] sum;
    logic [11:0] hden;
  } s2_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  k;
    logic [11:0] c;
    logic [23:0] lo_v;
    logic [33:0] mid_v;
    logic [34:0] half;
    logic [34:0] base;
    logic [33:0] ct;
    logic [25:0] hue_num;
    logic [23:0] sat_num;
    logic [11:0] mx;
    logic [11:0] d;
    logic [12:0] sum;
    logic [11:0] hden;
  } s3_t;

  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
  } frac_t;

  typedef struct packed {
    logic [LANES-1:0][RW-1:0] rem;
    logic [LANES-1:0][DW-1:0] den;
    logic [LANES-1:0][QW-1:0] q;
  } div_t;

endpackage

`default_nettype wire

### hdl/csc_if.sv
// ----------------------------------------------------------------------------
// csc_in_if / csc_out_if
// Valid/ready channels carrying one color triple per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface csc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [12:0] in_first;
  logic [11:0] in_second;
  logic [11:0] in_third;

  modport source (output valid, command, in_first, in_second, in_third, input ready);
  modport sink   (input valid, command, in_first, in_second, in_third, output ready);
endinterface

interface csc_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] out_first;
  logic [11:0] out_second;
  logic [11:0] out_third;

  modport source (output valid, out_first, out_second, out_third, input ready);
  modport sink   (input valid, out_first, out_second, out_third, output ready);
endinterface

`default_nettype wire

### hdl/csc_front.sv
// ----------------------------------------------------------------------------
// csc_front
// Five-stage front end: decode, two multiply stages, lane setup and
// rounding-divider operand forming.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  wire logic [1:0]   command_i,
  input  wire logic [12:0]  first_i,
  input  wire logic [11:0]  second_i,
  input  wire logic [11:0]  third_i,
  output logic              ready_o,
  output logic              valid_o,
  output csc_pkg::div_t     data_o,
  input  wire logic         ready_i
);

  logic [4:0] v_q;
  logic [5:0] rdy;

  always_comb begin
    rdy[5] = ready_i;
    for (int i = 4; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end
  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int i = 1; i < 5; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // ---------------- stage 1: decode ----------------
  csc_pkg::s1_t s1_d, s1_q;
  logic [12:0] h, kbase, twol, ab;
  logic [11:0] mn, l_in;
  logic [2:0]  k;
  logic [9:0]  f;

  always_comb begin
    h = (first_i >= 13'(csc_pkg::TURN)) ? first_i - 13'(csc_pkg::TURN) : first_i;
    if (h < 13'(csc_pkg::SEXT))          k = 3'd0;
    else if (h < 13'(2 * csc_pkg::SEXT)) k = 3'd1;
    else if (h < 13'(3 * csc_pkg::SEXT)) k = 3'd2;
    else if (h < 13'(4 * csc_pkg::SEXT)) k = 3'd3;
    else if (h < 13'(5 * csc_pkg::SEXT)) k = 3'd4;
    else                                 k = 3'd5;
    kbase = 13'(k) * 13'(csc_pkg::SEXT);
    f = 10'(h - kbase);

    s1_d.cmd = csc_pkg::cmd_e'(command_i);
    s1_d.k   = k;
    s1_d.t   = k[0] ? 10'(csc_pkg::SEXT) - f : f;
    s1_d.s   = second_i;
    s1_d.c   = third_i;
    l_in     = third_i;
    twol     = {l_in, 1'b0};
    ab = (twol >= 13'(csc_pkg::FULL)) ? twol - 13'(csc_pkg::FULL)
                                      : 13'(csc_pkg::FULL) - twol;
    s1_d.ch  = 12'(13'(csc_pkg::FULL) - ab);

    s1_d.r = (first_i > 13'(csc_pkg::FULL)) ? 12'(csc_pkg::FULL) : first_i[11:0];
    s1_d.g = second_i;
    s1_d.b = third_i;
    s1_d.mx = s1_d.r;
    if (s1_d.g > s1_d.mx) s1_d.mx = s1_d.g;
    if (s1_d.b > s1_d.mx) s1_d.mx = s1_d.b;
    mn = s1_d.r;
    if (s1_d.g < mn) mn = s1_d.g;
    if (s1_d.b < mn) mn = s1_d.b;
    s1_d.d   = s1_d.mx - mn;
    s1_d.sum = 13'(s1_d.mx) + 13'(mn);
    s1_d.hden = (s1_d.sum >= 13'(csc_pkg::FULL))
              ? 12'(13'(2 * csc_pkg::FULL) - s1_d.sum) : s1_d.sum[11:0];
    // ties go to red, then green
    if (s1_d.mx == s1_d.r)      s1_d.src = csc_pkg::SRC_R;
    else if (s1_d.mx == s1_d.g) s1_d.src = csc_pkg::SRC_G;
    else                        s1_d.src = csc_pkg::SRC_B;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) s1_q <= s1_d;
  end

  // ---------------- stage 2: first products ----------------
  csc_pkg::s2_t s2_d, s2_q;

  always_comb begin
    s2_d.cmd  = s1_q.cmd;
    s2_d.k    = s1_q.k;
    s2_d.t    = s1_q.t;
    s2_d.c    = s1_q.c;
    s2_d.p_sv = 22'(s1_q.s) * 22'(10'(csc_pkg::SEXT) - s1_q.t);
    s2_d.lo_v = 24'(s1_q.c) * 24'(12'(csc_pkg::FULL) - s1_q.s);
    s2_d.cs   = 24'(s1_q.ch) * 24'(s1_q.s);
    case (s1_q.src)
      csc_pkg::SRC_R: begin
        if (s1_q.g >= s1_q.b) begin
          s2_d.hue_num = 26'(csc_pkg::SEXT) * 26'(s1_q.g - s1_q.b);
        end else begin
          s2_d.hue_num = 26'(csc_pkg::TURN) * 26'(s1_q.d)
                       - 26'(csc_pkg::SEXT) * 26'(s1_q.b - s1_q.g);
        end
      end
      csc_pkg::SRC_G: begin
        s2_d.hue_num = 26'(2 * csc_pkg::SEXT) * 26'(s1_q.d)
                     + 26'(csc_pkg::SEXT) * 26'(s1_q.b)
                     - 26'(csc_pkg::SEXT) * 26'(s1_q.r);
      end
      default: begin
        s2_d.hue_num = 26'(4 * csc_pkg::SEXT) * 26'(s1_q.d)
                     + 26'(csc_pkg::SEXT) * 26'(s1_q.r)
                     - 26'(csc_pkg::SEXT) * 26'(s1_q.g);
      end
    endcase
    s2_d.sat_num = 24'(s1_q.d) * 24'(csc_pkg::FULL);
    s2_d.mx   = s1_q.mx;
    s2_d.d    = s1_q.d;
    s2_d.sum  = s1_q.sum;
    s2_d.hden = s1_q.hden;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) s2_q <= s2_d;
  end

  // ---------------- stage 3: second products ----------------
  csc_pkg::s3_t s3_d, s3_q;

  always_comb begin
    s3_d.cmd     = s2_q.cmd;
    s3_d.k       = s2_q.k;
    s3_d.c       = s2_q.c;
    s3_d.lo_v    = s2_q.lo_v;
    s3_d.mid_v   = 34'(s2_q.c) * 34'(22'(csc_pkg::FSEXT) - s2_q.p_sv);
    s3_d.half    = 35'(s2_q.cs) * 35'(csc_pkg::SEXT);
    s3_d.base    = 35'(s2_q.c) * 35'(csc_pkg::DEN2);
    s3_d.ct      = 34'(s2_q.cs) * 34'(s2_q.t);
    s3_d.hue_num = s2_q.hue_num;
    s3_d.sat_num = s2_q.sat_num;
    s3_d.mx      = s2_q.mx;
    s3_d.d       = s2_q.d;
    s3_d.sum     = s2_q.sum;
    s3_d.hden    = s2_q.hden;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) s3_q <= s3_d;
  end

  // ---------------- stage 4: lane setup ----------------
  csc_pkg::frac_t [csc_pkg::LANES-1:0] ln_d, ln_q;
  csc_pkg::frac_t hi, mid, lo, zero_f;
  logic [34:0] lo_d;

  always_comb begin
    zero_f = '{num: '0, den: 23'd1};
    lo_d   = s3_q.base - s3_q.half;
    if (s3_q.cmd == csc_pkg::CMD_HSV2RGB) begin
      hi  = '{num: 35'(s3_q.c),     den: 23'd1};
      mid = '{num: 35'(s3_q.mid_v), den: 23'(csc_pkg::FSEXT)};
      lo  = '{num: 35'(s3_q.lo_v),  den: 23'(csc_pkg::FULL)};
    end else begin
      hi  = '{num: s3_q.base + s3_q.half,       den: 23'(csc_pkg::DEN2)};
      mid = '{num: lo_d + {s3_q.ct, 1'b0},      den: 23'(csc_pkg::DEN2)};
      lo  = '{num: lo_d,                        den: 23'(csc_pkg::DEN2)};
    end

    case (s3_q.cmd)
      csc_pkg::CMD_HSV2RGB, csc_pkg::CMD_HSL2RGB: begin
        case (s3_q.k)
          3'd0: begin ln_d[0] = hi;  ln_d[1] = mid; ln_d[2] = lo;  end
          3'd1: begin ln_d[0] = mid; ln_d[1] = hi;  ln_d[2] = lo;  end
          3'd2: begin ln_d[0] = lo;  ln_d[1] = hi;  ln_d[2] = mid; end
          3'd3: begin ln_d[0] = lo;  ln_d[1] = mid; ln_d[2] = hi;  end
          3'd4: begin ln_d[0] = mid; ln_d[1] = lo;  ln_d[2] = hi;  end
          default: begin ln_d[0] = hi; ln_d[1] = lo; ln_d[2] = mid; end
        endcase
      end
      default: begin
        ln_d[0] = (s3_q.d != '0) ? '{num: 35'(s3_q.hue_num), den: 23'(s3_q.d)} : zero_f;
        if (s3_q.cmd == csc_pkg::CMD_RGB2HSV) begin
          ln_d[1] = (s3_q.mx != '0)
                  ? '{num: 35'(s3_q.sat_num), den: 23'(s3_q.mx)} : zero_f;
          ln_d[2] = '{num: 35'(s3_q.mx), den: 23'd1};
        end else begin
          ln_d[1] = (s3_q.d != '0 && s3_q.hden != '0)
                  ? '{num: 35'(s3_q.sat_num), den: 23'(s3_q.hden)} : zero_f;
          // (sum + 1) / 2 as a rounded halving
          ln_d[2] = '{num: 35'(s3_q.sum), den: 23'd2};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) ln_q <= ln_d;
  end

  // ---------------- stage 5: round-to-nearest operands ----------------
  csc_pkg::div_t dv_d, dv_q;

  always_comb begin
    for (int l = 0; l < csc_pkg::LANES; l++) begin
      dv_d.rem[l] = {ln_q[l].num, 1'b0} + csc_pkg::RW'(ln_q[l].den);
      dv_d.den[l] = {ln_q[l].den, 1'b0};
      dv_d.q[l]   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) dv_q <= dv_d;
  end

  assign valid_o = v_q[4];
  assign data_o  = dv_q;

endmodule

`default_nettype wire

### hdl/csc_divider.sv
// ----------------------------------------------------------------------------
// csc_divider
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_divider (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  csc_pkg::div_t       data_i,
  output logic                ready_o,
  output logic                valid_o,
  output csc_pkg::div_t       data_o,
  input  wire logic           ready_i
);

  localparam int unsigned N = csc_pkg::QW;

  logic [N-1:0]  v_q;
  logic [N:0]    rdy;
  csc_pkg::div_t st_q [N];

  assign rdy[N] = ready_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int unsigned B = N - 1 - i;
    csc_pkg::div_t src, nxt;
    logic v_src;
    logic [csc_pkg::RW-1:0] sh;

    assign rdy[i] = !v_q[i] || rdy[i+1];

    if (i == 0) begin : g_first
      assign src   = data_i;
      assign v_src = valid_i;
    end else begin : g_rest
      assign src   = st_q[i-1];
      assign v_src = v_q[i-1];
    end

    always_comb begin
      nxt = src;
      for (int l = 0; l < csc_pkg::LANES; l++) begin
        sh = csc_pkg::RW'(src.den[l]) << B;
        if (src.rem[l] >= sh) begin
          nxt.rem[l]  = src.rem[l] - sh;
          nxt.q[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_q[i] <= v_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i]) st_q[i] <= nxt;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[N-1];
  assign data_o  = st_q[N-1];

endmodule

`default_nettype wire

### hdl/color_space_converter.sv
// ----------------------------------------------------------------------------
// color_space_converter
// Converts HSV/HSL to RGB and back, one color per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one color per clock unless stalled and passes it through five
// front-end stages (decode, two multiply stages, lane setup, operand
// forming), a thirteen-stage divider that yields one quotient bit per
// stage on three lanes at once, and an output register. Fractions are
// 12-bit with 4095 as 1.0, hue is in 1/16 degree. Every stage holds its
// beat under back-pressure and empty stages fill, so a result waiting at
// the output does not stop new input while the pipe has room.
`default_nettype none

module color_space_converter (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  csc_in_if.sink         in_i,
  csc_out_if.source      out_o
);

  logic          f_valid, f_ready, d_valid, d_ready;
  csc_pkg::div_t f_data, d_data;

  csc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .command_i (in_i.command),
    .first_i   (in_i.in_first),
    .second_i  (in_i.in_second),
    .third_i   (in_i.in_third),
    .ready_o   (in_i.ready),
    .valid_o   (f_valid),
    .data_o    (f_data),
    .ready_i   (f_ready)
  );

  csc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .data_i  (f_data),
    .ready_o (f_ready),
    .valid_o (d_valid),
    .data_o  (d_data),
    .ready_i (d_ready)
  );

  logic        out_v_q;
  logic [12:0] first_q, first_d;
  logic [11:0] second_q, third_q;

  assign d_ready = !out_v_q || out_o.ready;

  // hue that rounds up to a full turn wraps to zero
  assign first_d = (d_data.q[0] >= 13'(csc_pkg::TURN))
                 ? d_data.q[0] - 13'(csc_pkg::TURN) : d_data.q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (d_ready) begin
      out_v_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready) begin
      first_q  <= first_d;
      second_q <= d_data.q[1][11:0];
      third_q  <= d_data.q[2][11:0];
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.out_first  = first_q;
  assign out_o.out_second = second_q;
  assign out_o.out_third  = third_q;

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.out_first < 13'(csc_pkg::TURN))
    else $error("hue out of range");

  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output drains");

endmodule

`default_nettype wire

### bench/csc_checker.sv
// ----------------------------------------------------------------------------
// csc_checker
// Watches both channels of the color space converter, predicts each result
// from the accepted input beat and compares it with the next output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csc_in_if.sink    in_i,
  csc_out_if.sink   out_o,
  output int        fails_o,
  output int        pending_o,
  output int        results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [12:0] first;
    logic [11:0] second;
    logic [11:0] third;
  } triple_t;

  triple_t color_q[$];

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    if (den == 0) return 0;
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic longint unsigned clip(longint unsigned x);
    return (x > csc_pkg::FULL) ? csc_pkg::FULL : x;
  endfunction

  function automatic triple_t convert(csc_pkg::cmd_e cmd, logic [12:0] a, logic [11:0] b,
                                      logic [11:0] c);
    longint unsigned h, k, f, t, s, v, hi, mid, lo, l, twol, ab, ch, den, base, half;
    longint unsigned r, g, bl, mx, mn, d, num, sum, o0, o1, o2;
    triple_t res;
    o0 = 0; o1 = 0; o2 = 0;
    s = clip(64'(b));
    v = clip(64'(c));
    if (cmd == csc_pkg::CMD_HSV2RGB || cmd == csc_pkg::CMD_HSL2RGB) begin
      h = a % csc_pkg::TURN;
      k = h / csc_pkg::SEXT;
      f = h % csc_pkg::SEXT;
      t = k[0] ? csc_pkg::SEXT - f : f;
      if (cmd == csc_pkg::CMD_HSV2RGB) begin
        hi  = v;
        lo  = round_div(v * (csc_pkg::FULL - s), csc_pkg::FULL);
        mid = round_div(v * (csc_pkg::FULL * csc_pkg::SEXT - s * (csc_pkg::SEXT - t)),
                        csc_pkg::FULL * csc_pkg::SEXT);
      end else begin
        l    = v;
        twol = 2 * l;
        ab   = (twol >= csc_pkg::FULL) ? twol - csc_pkg::FULL : csc_pkg::FULL - twol;
        ch   = csc_pkg::FULL - ab;
        den  = 2 * csc_pkg::FULL * csc_pkg::SEXT;
        base = den * l;
        half = ch * s * csc_pkg::SEXT;
        hi   = round_div(base + half, den);
        lo   = round_div(base - half, den);
        mid  = round_div(base - half + 2 * ch * s * t, den);
      end
      case (k)
        0: begin o0 = hi;  o1 = mid; o2 = lo;  end
        1: begin o0 = mid; o1 = hi;  o2 = lo;  end
        2: begin o0 = lo;  o1 = hi;  o2 = mid; end
        3: begin o0 = lo;  o1 = mid; o2 = hi;  end
        4: begin o0 = mid; o1 = lo;  o2 = hi;  end
        default: begin o0 = hi; o1 = lo; o2 = mid; end
      endcase
    end else begin
      r = clip(64'(a)); g = s; bl = v;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (bl > mx) mx = bl;
      if (g < mn) mn = g;
      if (bl < mn) mn = bl;
      d = mx - mn;
      if (d != 0) begin
        // red wins ties, then green
        if (mx == r) num = (g >= bl) ? csc_pkg::SEXT * (g - bl)
                                     : csc_pkg::TURN * d - csc_pkg::SEXT * (bl - g);
        else if (mx == g) num = 2 * csc_pkg::SEXT * d + csc_pkg::SEXT * bl
                              - csc_pkg::SEXT * r;
        else num = 4 * csc_pkg::SEXT * d + csc_pkg::SEXT * r - csc_pkg::SEXT * g;
        o0 = round_div(num, d);
        if (o0 >= csc_pkg::TURN) o0 -= csc_pkg::TURN;
      end
      if (cmd == csc_pkg::CMD_RGB2HSV) begin
        o1 = (mx != 0) ? round_div(d * csc_pkg::FULL, mx) : 0;
        o2 = mx;
      end else begin
        sum = mx + mn;
        den = (sum >= csc_pkg::FULL) ? 2 * csc_pkg::FULL - sum : sum;
        o1  = (d != 0 && den != 0) ? round_div(d * csc_pkg::FULL, den) : 0;
        o2  = (sum + 1) / 2;
      end
    end
    res.first  = o0[12:0];
    res.second = o1[11:0];
    res.third  = o2[11:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    triple_t want, got;
    if (!rst_ni) begin
      fails_o   <= 0;
      results_o <= 0;
      pending_o <= 0;
      color_q.delete();
    end else begin
      if (in_i.valid && in_i.ready)
        color_q.push_back(convert(csc_pkg::cmd_e'(in_i.command), in_i.in_first,
                                  in_i.in_second, in_i.in_third));
      if (out_o.valid && out_o.ready) begin
        got = {out_o.out_first, out_o.out_second, out_o.out_third};
        results_o <= results_o + 1;
        if (color_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %0d/%0d/%0d", $time,
                   got.first, got.second, got.third);
          fails_o <= fails_o + 1;
        end else begin
          want = color_q.pop_front();
          if (want != got) begin
            $display("%0t: mismatch, expected %0d/%0d/%0d, actual %0d/%0d/%0d", $time,
                     want.first, want.second, want.third, got.first, got.second, got.third);
            fails_o <= fails_o + 1;
          end
        end
      end
      pending_o <= color_q.size();
    end
  end

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the color space converter with directed and random colors on all
// four commands under varying idle and stall patterns; the checker grades it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   fails, pending, results, sent;
  int   send_idle, recv_stall;
  bit   hold_off;

  csc_in_if  in_ch();
  csc_out_if out_ch();

  color_space_converter uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  csc_checker checker_i (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
                         .fails_o(fails), .pending_o(pending), .results_o(results));

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("[color_space_converter] ERROR");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    int n;
    out_ch.ready = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 0;
        for (n = 0; n < 60; n++) @(posedge clk_i);
        hold_off = 0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send(logic [1:0] cmd, logic [12:0] a, logic [11:0] b, logic [11:0] c);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1;
    in_ch.command   <= cmd;
    in_ch.in_first  <= a;
    in_ch.in_second <= b;
    in_ch.in_third  <= c;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_random();
    logic [1:0]  cmd;
    logic [12:0] a;
    cmd = 2'($urandom_range(3));
    if ($urandom_range(9) == 0) a = 13'($urandom);
    else if (cmd[0]) a = 13'($urandom_range(csc_pkg::FULL));
    else a = 13'($urandom_range(csc_pkg::TURN - 1));
    case ($urandom_range(5))
      0: send(cmd, a, a[11:0], a[11:0]);                       // grey / ties
      1: send(cmd, a, 12'($urandom_range(csc_pkg::FULL)), a[11:0]);
      default: send(cmd, a, 12'($urandom), 12'($urandom));
    endcase
  endtask

  initial begin
    int i, ph;
    in_ch.valid = 0;
    in_ch.command = csc_pkg::CMD_HSV2RGB;
    in_ch.in_first = 0;
    in_ch.in_second = 0;
    in_ch.in_third = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 0;
    sent = 0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // extremes, sextant edges, grey, black, ties, saturating and wrapping inputs
    send(csc_pkg::CMD_HSV2RGB, 13'd0, 12'd4095, 12'd4095);
    send(csc_pkg::CMD_HSV2RGB, 13'd5759, 12'd4095, 12'd4095);
    send(csc_pkg::CMD_HSV2RGB, 13'd960, 12'd2048, 12'd3000);
    send(csc_pkg::CMD_HSV2RGB, 13'h1FFF, 12'hFFF, 12'hFFF);
    send(csc_pkg::CMD_HSV2RGB, 13'd3360, 12'd0, 12'd0);
    send(csc_pkg::CMD_HSL2RGB, 13'd0, 12'd4095, 12'd2048);
    send(csc_pkg::CMD_HSL2RGB, 13'd4801, 12'd4095, 12'd4095);
    send(csc_pkg::CMD_HSL2RGB, 13'h1FFF, 12'hFFF, 12'd0);
    send(csc_pkg::CMD_HSL2RGB, 13'd1927, 12'd1234, 12'd2047);
    send(csc_pkg::CMD_RGB2HSV, 13'd0, 12'd0, 12'd0);
    send(csc_pkg::CMD_RGB2HSV, 13'd4095, 12'd4095, 12'd4095);
    send(csc_pkg::CMD_RGB2HSV, 13'd4095, 12'd4095, 12'd0);
    send(csc_pkg::CMD_RGB2HSV, 13'd0, 12'd4095, 12'd4095);
    send(csc_pkg::CMD_RGB2HSV, 13'd4095, 12'd0, 12'd4095);
    send(csc_pkg::CMD_RGB2HSV, 13'd4095, 12'd0, 12'd1);
    send(csc_pkg::CMD_RGB2HSV, 13'h1FFF, 12'd0, 12'd0);
    send(csc_pkg::CMD_RGB2HSL, 13'd0, 12'd0, 12'd0);
    send(csc_pkg::CMD_RGB2HSL, 13'd4095, 12'd4095, 12'd4095);
    send(csc_pkg::CMD_RGB2HSL, 13'd2048, 12'd2047, 12'd2047);
    send(csc_pkg::CMD_RGB2HSL, 13'd4095, 12'd1, 12'd0);
    send(csc_pkg::CMD_RGB2HSL, 13'd100, 12'd4095, 12'd4094);
    send(csc_pkg::CMD_RGB2HSL, 13'h1FFF, 12'hFFF, 12'hFFE);

    for (ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 79 : 24) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 79 : 24) : 0;
      if (ph == 0) hold_off = 1;     // fill the pipe and stall the input
      for (i = 0; i < 120; i++) send_random();
      in_ch.valid <= 0;
      // pause until the pipe has drained
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
    end
    in_ch.valid <= 0;
    recv_stall = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("Sent %0d colors over all four commands, %0d results checked.", sent, results);
    if (fails == 0 && pending == 0 && results == sent)
      $display("[color_space_converter] OK");
    else $display("[color_space_converter] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
